FILE: hdl/timed_light_door_controller_unit_macros.svh
// assertion macros used by the checker file
`ifndef TIMED_LIGHT_DOOR_CONTROLLER_UNIT_MACROS_SVH
`define TIMED_LIGHT_DOOR_CONTROLLER_UNIT_MACROS_SVH

// property checked outside reset
`define TLDC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// property checked on every edge, reset included
`define TLDC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/tldc_pkg.sv
// ----------------------------------------------------------------------------
// tldc_pkg
// types, register map and command codes of the timed light door controller
// ----------------------------------------------------------------------------
`default_nettype none

package tldc_pkg;

  localparam int MINUTE_W = 11;
  localparam int LEVEL_W  = 8;
  localparam int SAMPLE_W = 10;
  localparam int STREAK_W = 8;
  localparam int MODE_W   = 2;
  localparam int CMD_W    = 2;
  localparam int ADDR_W   = 5;
  localparam int DATA_W   = 32;
  localparam int IDX_W    = 3;

  // door commands
  localparam logic [CMD_W-1:0] CMD_NONE  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_OPEN  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLOSE = 2'd2;

  // register indexes
  localparam logic [IDX_W-1:0] REG_EARLIEST_OPEN = 3'd0;
  localparam logic [IDX_W-1:0] REG_FORCED_OPEN   = 3'd1;
  localparam logic [IDX_W-1:0] REG_EVENING       = 3'd2;
  localparam logic [IDX_W-1:0] REG_FORCED_CLOSE  = 3'd3;
  localparam logic [IDX_W-1:0] REG_OPEN_LEVEL    = 3'd4;
  localparam logic [IDX_W-1:0] REG_CLOSE_LEVEL   = 3'd5;
  localparam logic [IDX_W-1:0] REG_NEEDED_STREAK = 3'd6;
  localparam logic [IDX_W-1:0] REG_MODE_BITS     = 3'd7;

  // register reset values
  localparam logic [MINUTE_W-1:0] RST_EARLIEST_OPEN = 11'd420;
  localparam logic [MINUTE_W-1:0] RST_FORCED_OPEN   = 11'd540;
  localparam logic [MINUTE_W-1:0] RST_EVENING       = 11'd1140;
  localparam logic [MINUTE_W-1:0] RST_FORCED_CLOSE  = 11'd1320;
  localparam logic [LEVEL_W-1:0]  RST_OPEN_LEVEL    = 8'd128;
  localparam logic [LEVEL_W-1:0]  RST_CLOSE_LEVEL   = 8'd64;
  localparam logic [STREAK_W-1:0] RST_NEEDED_STREAK = 8'd4;
  localparam logic [MODE_W-1:0]   RST_MODE_BITS     = 2'd0;

  localparam logic [STREAK_W-1:0] STREAK_MAX = '1;

  // mode bits
  localparam int MODE_FIXED  = 0;
  localparam int MODE_INSIDE = 1;

  typedef struct packed {
    logic [MINUTE_W-1:0] earliest_open_minute;
    logic [MINUTE_W-1:0] forced_open_minute;
    logic [MINUTE_W-1:0] evening_minute;
    logic [MINUTE_W-1:0] forced_close_minute;
    logic [LEVEL_W-1:0]  open_level;
    logic [LEVEL_W-1:0]  close_level;
    logic [STREAK_W-1:0] needed_streak;
    logic [MODE_W-1:0]   mode_bits;
  } cfg_t;

  typedef struct packed {
    logic [MINUTE_W-1:0] now_minute;
    logic                door_is_open;
    logic [SAMPLE_W-1:0] light_outside;
    logic [SAMPLE_W-1:0] light_inside;
  } tick_t;

  typedef struct packed {
    logic [CMD_W-1:0]    door_command;
    logic [STREAK_W-1:0] streak_now;
  } verdict_t;

endpackage

`default_nettype wire

FILE: hdl/timed_light_door_controller_unit.sv
// ----------------------------------------------------------------------------
// timed_light_door_controller_unit
// door controller driven by time of day, door position and light samples
// ----------------------------------------------------------------------------
// One tick is accepted per clock while the result side is not stalled, and
// each tick yields exactly one result: the tick lands in an input register,
// the decision logic runs between that register and the result register, and
// the streak counter is updated at the edge where the tick moves into the
// result register. While the result register is held by out_ready low, one
// more tick can still be taken into the input register. Registers are written
// through the apb port and take effect for ticks that reach the decision stage
// later.
`default_nettype none

module timed_light_door_controller_unit (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // tick channel
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [tldc_pkg::MINUTE_W-1:0] in_now_minute,
  input  wire logic                          in_door_is_open,
  input  wire logic [tldc_pkg::SAMPLE_W-1:0] in_light_outside,
  input  wire logic [tldc_pkg::SAMPLE_W-1:0] in_light_inside,
  // result channel
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic      [tldc_pkg::CMD_W-1:0]    out_door_command,
  output logic      [tldc_pkg::STREAK_W-1:0] out_streak_now,
  // configuration port
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [tldc_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [tldc_pkg::DATA_W-1:0]   pwdata,
  output logic      [tldc_pkg::DATA_W-1:0]   prdata,
  output logic                               pready
);
  import tldc_pkg::*;

  cfg_t                cfg;
  tick_t               tick_r;
  logic                tick_vld_r;
  verdict_t            verdict_nxt;
  verdict_t            verdict_r;
  logic                out_valid_r;
  logic [STREAK_W-1:0] streak_r;
  logic                advance;

  // register file
  tldc_cfg_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // handshake flow
  assign advance  = tick_vld_r && (!out_valid_r || out_ready);
  assign in_ready = !tick_vld_r || advance;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
      streak_r    <= '0;
    end else begin
      if (in_ready) tick_vld_r <= in_valid;
      if (advance) begin
        out_valid_r <= 1'b1;
        streak_r    <= verdict_nxt.streak_now;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // input payload register
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      tick_r.now_minute    <= in_now_minute;
      tick_r.door_is_open  <= in_door_is_open;
      tick_r.light_outside <= in_light_outside;
      tick_r.light_inside  <= in_light_inside;
    end
  end

  // decision logic
  tldc_decide u_decide (
    .cfg     (cfg),
    .tick    (tick_r),
    .streak  (streak_r),
    .verdict (verdict_nxt)
  );

  // result payload register
  always_ff @(posedge clk) begin
    if (advance) verdict_r <= verdict_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_door_command = verdict_r.door_command;
  assign out_streak_now   = verdict_r.streak_now;

endmodule

`default_nettype wire

FILE: hdl/tldc_cfg_regs.sv
// ----------------------------------------------------------------------------
// tldc_cfg_regs
// apb register file holding the schedule, light thresholds and mode
// ----------------------------------------------------------------------------
`default_nettype none

module tldc_cfg_regs (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [tldc_pkg::ADDR_W-1:0] paddr,
  input  wire logic [tldc_pkg::DATA_W-1:0] pwdata,
  output logic      [tldc_pkg::DATA_W-1:0] prdata,
  output logic                             pready,
  output tldc_pkg::cfg_t                   cfg
);
  import tldc_pkg::*;

  cfg_t              cfg_r;
  logic [IDX_W-1:0]  reg_idx;
  logic              wr_en;

  assign reg_idx = paddr[ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg     = cfg_r;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.earliest_open_minute <= RST_EARLIEST_OPEN;
      cfg_r.forced_open_minute   <= RST_FORCED_OPEN;
      cfg_r.evening_minute       <= RST_EVENING;
      cfg_r.forced_close_minute  <= RST_FORCED_CLOSE;
      cfg_r.open_level           <= RST_OPEN_LEVEL;
      cfg_r.close_level          <= RST_CLOSE_LEVEL;
      cfg_r.needed_streak        <= RST_NEEDED_STREAK;
      cfg_r.mode_bits            <= RST_MODE_BITS;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_EARLIEST_OPEN: cfg_r.earliest_open_minute <= pwdata[MINUTE_W-1:0];
        REG_FORCED_OPEN:   cfg_r.forced_open_minute   <= pwdata[MINUTE_W-1:0];
        REG_EVENING:       cfg_r.evening_minute       <= pwdata[MINUTE_W-1:0];
        REG_FORCED_CLOSE:  cfg_r.forced_close_minute  <= pwdata[MINUTE_W-1:0];
        REG_OPEN_LEVEL:    cfg_r.open_level           <= pwdata[LEVEL_W-1:0];
        REG_CLOSE_LEVEL:   cfg_r.close_level          <= pwdata[LEVEL_W-1:0];
        REG_NEEDED_STREAK: cfg_r.needed_streak        <= pwdata[STREAK_W-1:0];
        REG_MODE_BITS:     cfg_r.mode_bits            <= pwdata[MODE_W-1:0];
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (reg_idx)
      REG_EARLIEST_OPEN: prdata = DATA_W'(cfg_r.earliest_open_minute);
      REG_FORCED_OPEN:   prdata = DATA_W'(cfg_r.forced_open_minute);
      REG_EVENING:       prdata = DATA_W'(cfg_r.evening_minute);
      REG_FORCED_CLOSE:  prdata = DATA_W'(cfg_r.forced_close_minute);
      REG_OPEN_LEVEL:    prdata = DATA_W'(cfg_r.open_level);
      REG_CLOSE_LEVEL:   prdata = DATA_W'(cfg_r.close_level);
      REG_NEEDED_STREAK: prdata = DATA_W'(cfg_r.needed_streak);
      REG_MODE_BITS:     prdata = DATA_W'(cfg_r.mode_bits);
    endcase
  end

endmodule

`default_nettype wire

FILE: hdl/tldc_decide.sv
// ----------------------------------------------------------------------------
// tldc_decide
// per-tick decision: schedule rules, light window check and streak update
// ----------------------------------------------------------------------------
`default_nettype none

module tldc_decide (
  input  wire tldc_pkg::cfg_t                cfg,
  input  wire tldc_pkg::tick_t               tick,
  input  wire logic [tldc_pkg::STREAK_W-1:0] streak,
  output tldc_pkg::verdict_t                 verdict
);
  import tldc_pkg::*;

  logic                now_after_early;
  logic                now_before_fopen;
  logic                now_after_fopen;
  logic                now_before_eve;
  logic                now_before_early;
  logic                now_after_fclose;
  logic                morning;
  logic [LEVEL_W-1:0]  level;
  logic                qualifies;
  logic [STREAK_W-1:0] streak_inc;

  // strict time compares
  assign now_after_early  = tick.now_minute > cfg.earliest_open_minute;
  assign now_before_early = cfg.earliest_open_minute > tick.now_minute;
  assign now_before_fopen = cfg.forced_open_minute > tick.now_minute;
  assign now_after_fopen  = tick.now_minute > cfg.forced_open_minute;
  assign now_before_eve   = cfg.evening_minute > tick.now_minute;
  assign now_after_fclose = tick.now_minute > cfg.forced_close_minute;
  assign morning          = now_after_early && now_before_fopen;

  // scaled light level from the chosen sensor
  assign level = cfg.mode_bits[MODE_INSIDE] ? tick.light_inside[SAMPLE_W-1:2]
                                            : tick.light_outside[SAMPLE_W-1:2];
  assign qualifies = morning ? (level > cfg.open_level) : (level < cfg.close_level);

  // saturating streak step
  always_comb begin
    if (!qualifies) begin
      streak_inc = '0;
    end else if (streak == STREAK_MAX) begin
      streak_inc = STREAK_MAX;
    end else begin
      streak_inc = streak + STREAK_W'(1);
    end
  end

  // rule priority
  always_comb begin
    verdict.door_command = CMD_NONE;
    verdict.streak_now   = streak;
    priority if (cfg.mode_bits[MODE_FIXED]) begin
      if (now_after_early && now_before_eve) begin
        if (!tick.door_is_open) verdict.door_command = CMD_OPEN;
      end else begin
        if (tick.door_is_open) verdict.door_command = CMD_CLOSE;
      end
    end else if (now_before_early || now_after_fclose) begin
      if (tick.door_is_open) verdict.door_command = CMD_CLOSE;
    end else if (now_after_fopen && now_before_eve) begin
      if (!tick.door_is_open) verdict.door_command = CMD_OPEN;
    end else if (morning != tick.door_is_open) begin
      if (streak_inc >= cfg.needed_streak) begin
        verdict.door_command = morning ? CMD_OPEN : CMD_CLOSE;
        verdict.streak_now   = '0;
      end else begin
        verdict.streak_now   = streak_inc;
      end
    end else begin
      // door already at the window target: streak held
      verdict.streak_now = streak;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/tldc_checker.sv
// ----------------------------------------------------------------------------
// tldc_checker
// port-level checks of the door controller, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "timed_light_door_controller_unit_macros.svh"

module tldc_checker (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_ready,
  input  wire logic                          out_valid,
  input  wire logic                          out_ready,
  input  wire logic [tldc_pkg::CMD_W-1:0]    out_door_command,
  input  wire logic [tldc_pkg::STREAK_W-1:0] out_streak_now
);
  import tldc_pkg::*;

  // reset empties both stages and opens the input
  `TLDC_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid && in_ready, "reset did not empty the pipeline")

  // with the result side empty nothing can stall the input
  `TLDC_ASSERT(a_ready_when_empty, clk, rst_n, !out_valid |-> in_ready, "input stalled with empty result register")

  // only defined command codes leave the block
  `TLDC_ASSERT(a_cmd_code, clk, rst_n, out_valid |-> (out_door_command == CMD_NONE || out_door_command == CMD_OPEN || out_door_command == CMD_CLOSE), "undefined door command")

  // a stalled result holds
  `TLDC_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_door_command) && $stable(out_streak_now), "stalled result changed")

endmodule

bind timed_light_door_controller_unit tldc_checker u_tldc_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_door_command (out_door_command),
  .out_streak_now   (out_streak_now)
);

`default_nettype wire
